>>> rtl/sdh_pkg.sv
package sdh_pkg;

   localparam int SECTOR_BYTES = 512;
   localparam int BUF_AW       = $clog2(SECTOR_BYTES);

   // request kinds
   localparam logic [2:0] FUNC_INIT  = 3'd0;
   localparam logic [2:0] FUNC_READ  = 3'd1;
   localparam logic [2:0] FUNC_LOAD  = 3'd2;
   localparam logic [2:0] FUNC_WRITE = 3'd3;
   localparam logic [2:0] FUNC_EXCH  = 3'd4;

   // configuration register indexes
   localparam logic [2:0] CSR_IDLE_RETRY  = 3'd0;
   localparam logic [2:0] CSR_COND_RETRY  = 3'd1;
   localparam logic [2:0] CSR_OPC_RETRY   = 3'd2;
   localparam logic [2:0] CSR_RESP_POLL   = 3'd3;
   localparam logic [2:0] CSR_DATA_POLL   = 3'd4;

   // card command indexes
   localparam logic [5:0] CMD_GO_IDLE  = 6'd0;
   localparam logic [5:0] CMD_IF_COND  = 6'd8;
   localparam logic [5:0] CMD_RD_BLOCK = 6'd17;
   localparam logic [5:0] CMD_WR_BLOCK = 6'd24;
   localparam logic [5:0] CMD_OP_COND  = 6'd41;
   localparam logic [5:0] CMD_APP      = 6'd55;
   localparam logic [5:0] CMD_READ_OCR = 6'd58;

   localparam logic [31:0] ARG_IF_COND = 32'h0000_01AA;
   localparam logic [31:0] ARG_HCS     = 32'h4000_0000;
   localparam logic [7:0]  CRC_CMD8    = 8'h87;
   localparam logic [7:0]  CRC_OTHER   = 8'h95;
   localparam logic [7:0]  TOKEN_START = 8'hFE;
   localparam logic [7:0]  IDLE_BYTE   = 8'hFF;
   localparam logic [4:0]  DRESP_MASKED_OK = 5'h05;

   typedef struct packed {
      logic [7:0]  idle_retry;
      logic [7:0]  cond_retry;
      logic [15:0] opc_retry;
      logic [7:0]  resp_poll;
      logic [15:0] data_poll;
   } sdh_cfg_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       chip_select_n;
      logic       read_valid;
      logic [7:0] read_byte;
      logic       read_last;
      logic       done_res;
      logic       status;
      logic       high_capacity;
   } sdh_rsp_type;

   // byte n of the six-byte command frame
   function automatic logic [7:0] cmd_byte(input logic [5:0] idx, input logic [31:0] arg,
                                           input logic [9:0] n);
      logic [7:0] b;
      case (n)
         10'd0: b = {2'b01, idx};
         10'd1: b = arg[31:24];
         10'd2: b = arg[23:16];
         10'd3: b = arg[15:8];
         10'd4: b = arg[7:0];
         default: b = (idx == CMD_IF_COND) ? CRC_CMD8 : CRC_OTHER;
      endcase
      return b;
   endfunction

endpackage

>>> rtl/sdh_wbuf.sv
module sdh_wbuf (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [sdh_pkg::BUF_AW-1:0] wr_addr,
   input  logic [7:0]                 wr_data,
   input  logic [sdh_pkg::BUF_AW-1:0] rd_addr,
   output logic [7:0]                 rd_data
);

   logic [7:0] mem_ff [sdh_pkg::SECTOR_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/sdh_core.sv
module sdh_core (
   input  logic                       clock,
   input  logic                       reset,
   input  sdh_pkg::sdh_cfg_type       cfg,
   input  logic                       item_valid,
   input  logic [2:0]                 func,
   input  logic [31:0]                sector_address,
   input  logic [7:0]                 rx_byte,
   input  logic [7:0]                 buf_data,
   output logic [sdh_pkg::BUF_AW-1:0] buf_rd_addr,
   output logic                       buf_wr_en,
   output logic                       res_valid,
   output sdh_pkg::sdh_rsp_type       res
);

   localparam logic [4:0] PH_IDLE     = 5'd0;
   localparam logic [4:0] PH_INIT_CLK = 5'd1;
   localparam logic [4:0] PH_CMD_TX   = 5'd2;
   localparam logic [4:0] PH_CMD_POLL = 5'd3;
   localparam logic [4:0] PH_CMD_OCR  = 5'd4;
   localparam logic [4:0] PH_CMD_TAIL = 5'd5;
   localparam logic [4:0] PH_INIT_GAP = 5'd6;
   localparam logic [4:0] PH_RD_TOKEN = 5'd7;
   localparam logic [4:0] PH_RD_DATA  = 5'd8;
   localparam logic [4:0] PH_RD_TAIL  = 5'd9;
   localparam logic [4:0] PH_WR_TOKEN = 5'd10;
   localparam logic [4:0] PH_WR_DATA  = 5'd11;
   localparam logic [4:0] PH_WR_CRC   = 5'd12;
   localparam logic [4:0] PH_WR_RESP  = 5'd13;
   localparam logic [4:0] PH_WR_BUSY1 = 5'd14;
   localparam logic [4:0] PH_WR_GAP   = 5'd15;
   localparam logic [4:0] PH_WR_BUSY2 = 5'd16;

   localparam logic [9:0] SECTOR_CNT = 10'(sdh_pkg::SECTOR_BYTES);

   logic [4:0]  phase_ff, phase_in;
   logic        ba_ff, ba_in;
   logic        v2_ff, v2_in;
   logic [16:0] retry_ff, retry_in;
   logic [16:0] poll_ff, poll_in;
   logic [9:0]  bc_ff, bc_in;
   logic [5:0]  cidx_ff, cidx_in;
   logic [31:0] carg_ff, carg_in;
   logic [7:0]  lresp_ff, lresp_in;

   logic [9:0]  bc1;
   logic [16:0] rc1;
   logic        snd, do_start, do_fin, fin_st;
   logic [7:0]  snd_byte;
   logic [5:0]  st_idx;
   logic [31:0] st_arg;
   logic        rv, rl;
   logic [7:0]  rb;

   assign bc1 = bc_ff + 10'd1;
   assign rc1 = retry_ff + 17'd1;

   // next state and result for one item
   always_comb begin
      phase_in = phase_ff;
      ba_in    = ba_ff;
      v2_in    = v2_ff;
      retry_in = retry_ff;
      poll_in  = poll_ff;
      bc_in    = bc_ff;
      cidx_in  = cidx_ff;
      carg_in  = carg_ff;
      lresp_in = lresp_ff;
      snd      = 1'b0;
      snd_byte = sdh_pkg::IDLE_BYTE;
      do_start = 1'b0;
      st_idx   = sdh_pkg::CMD_GO_IDLE;
      st_arg   = '0;
      do_fin   = 1'b0;
      fin_st   = 1'b0;
      rv       = 1'b0;
      rb       = '0;
      rl       = 1'b0;
      buf_wr_en = 1'b0;

      if (item_valid) begin
         if (func == sdh_pkg::FUNC_EXCH) begin
            case (phase_ff)
               PH_INIT_CLK: begin
                  bc_in = bc1;
                  if (bc1 < 10'd10) begin
                     snd = 1'b1;
                  end else begin
                     retry_in = '0;
                     do_start = 1'b1;
                  end
               end
               PH_CMD_TX: begin
                  bc_in = bc1;
                  if (bc1 < 10'd6) begin
                     snd = 1'b1;
                     snd_byte = sdh_pkg::cmd_byte(cidx_ff, carg_ff, bc1);
                  end else begin
                     phase_in = PH_CMD_POLL;
                     poll_in = '0;
                     snd = 1'b1;
                  end
               end
               PH_CMD_POLL: begin
                  snd = 1'b1;
                  if (rx_byte == sdh_pkg::IDLE_BYTE && poll_ff <= {9'd0, cfg.resp_poll}) begin
                     poll_in = poll_ff + 17'd1;
                  end else begin
                     lresp_in = rx_byte;
                     bc_in = '0;
                     phase_in = (rx_byte == 8'd0 && cidx_ff == sdh_pkg::CMD_READ_OCR) ?
                                PH_CMD_OCR : PH_CMD_TAIL;
                  end
               end
               PH_CMD_OCR: begin
                  if (bc_ff == 10'd0) begin
                     ba_in = rx_byte[6];
                  end
                  bc_in = bc1;
                  if (bc1 >= 10'd4) begin
                     phase_in = PH_CMD_TAIL;
                  end
                  snd = 1'b1;
               end
               PH_CMD_TAIL: begin
                  // response handling per command
                  case (cidx_ff)
                     sdh_pkg::CMD_GO_IDLE: begin
                        if (lresp_ff == 8'd1) begin
                           phase_in = PH_INIT_GAP;
                           bc_in = '0;
                           snd = 1'b1;
                        end else if (retry_ff > {9'd0, cfg.idle_retry}) begin
                           do_fin = 1'b1;
                           fin_st = 1'b1;
                        end else begin
                           retry_in = rc1;
                           do_start = 1'b1;
                        end
                     end
                     sdh_pkg::CMD_IF_COND: begin
                        if (lresp_ff == 8'd1) begin
                           retry_in = '0;
                           do_start = 1'b1;
                           st_idx = sdh_pkg::CMD_APP;
                        end else if (retry_ff > {9'd0, cfg.cond_retry}) begin
                           v2_in = 1'b0;
                           retry_in = '0;
                           do_start = 1'b1;
                           st_idx = sdh_pkg::CMD_APP;
                        end else begin
                           retry_in = rc1;
                           do_start = 1'b1;
                           st_idx = sdh_pkg::CMD_IF_COND;
                           st_arg = sdh_pkg::ARG_IF_COND;
                        end
                     end
                     sdh_pkg::CMD_APP: begin
                        do_start = 1'b1;
                        st_idx = sdh_pkg::CMD_OP_COND;
                        st_arg = sdh_pkg::ARG_HCS;
                     end
                     sdh_pkg::CMD_OP_COND: begin
                        retry_in = rc1;
                        if (rc1 > {1'b0, cfg.opc_retry}) begin
                           do_fin = 1'b1;
                           fin_st = 1'b1;
                        end else if (lresp_ff != 8'd0) begin
                           do_start = 1'b1;
                           st_idx = sdh_pkg::CMD_APP;
                        end else begin
                           retry_in = '0;
                           ba_in = 1'b0;
                           if (v2_ff) begin
                              do_start = 1'b1;
                              st_idx = sdh_pkg::CMD_READ_OCR;
                           end else begin
                              do_fin = 1'b1;
                           end
                        end
                     end
                     sdh_pkg::CMD_READ_OCR: begin
                        if (lresp_ff == 8'd0 || retry_ff > {9'd0, cfg.cond_retry}) begin
                           do_fin = 1'b1;
                        end else begin
                           retry_in = rc1;
                           do_start = 1'b1;
                           st_idx = sdh_pkg::CMD_READ_OCR;
                        end
                     end
                     sdh_pkg::CMD_RD_BLOCK: begin
                        if (lresp_ff != 8'd0) begin
                           do_fin = 1'b1;
                           fin_st = 1'b1;
                        end else begin
                           phase_in = PH_RD_TOKEN;
                           poll_in = '0;
                           snd = 1'b1;
                        end
                     end
                     default: begin
                        if (lresp_ff != 8'd0) begin
                           do_fin = 1'b1;
                           fin_st = 1'b1;
                        end else begin
                           phase_in = PH_WR_TOKEN;
                           snd = 1'b1;
                           snd_byte = sdh_pkg::TOKEN_START;
                        end
                     end
                  endcase
               end
               PH_INIT_GAP: begin
                  bc_in = bc1;
                  if (bc1 < 10'd2) begin
                     snd = 1'b1;
                  end else begin
                     retry_in = '0;
                     do_start = 1'b1;
                     st_idx = sdh_pkg::CMD_IF_COND;
                     st_arg = sdh_pkg::ARG_IF_COND;
                  end
               end
               PH_RD_TOKEN: begin
                  if (rx_byte == sdh_pkg::TOKEN_START) begin
                     phase_in = PH_RD_DATA;
                     bc_in = '0;
                     snd = 1'b1;
                  end else if (poll_ff > {1'b0, cfg.data_poll}) begin
                     do_fin = 1'b1;
                     fin_st = 1'b1;
                  end else begin
                     poll_in = poll_ff + 17'd1;
                     snd = 1'b1;
                  end
               end
               PH_RD_DATA: begin
                  rl = (bc1 >= SECTOR_CNT);
                  bc_in = bc1;
                  if (rl) begin
                     phase_in = PH_RD_TAIL;
                     bc_in = '0;
                  end
                  snd = 1'b1;
                  rv = 1'b1;
                  rb = rx_byte;
               end
               PH_RD_TAIL: begin
                  bc_in = bc1;
                  if (bc1 < 10'd3) begin
                     snd = 1'b1;
                  end else begin
                     do_fin = 1'b1;
                  end
               end
               PH_WR_TOKEN: begin
                  phase_in = PH_WR_DATA;
                  bc_in = '0;
                  snd = 1'b1;
                  snd_byte = buf_data;
               end
               PH_WR_DATA: begin
                  bc_in = bc1;
                  snd = 1'b1;
                  if (bc1 < SECTOR_CNT) begin
                     snd_byte = buf_data;
                  end else begin
                     phase_in = PH_WR_CRC;
                     bc_in = '0;
                  end
               end
               PH_WR_CRC: begin
                  bc_in = bc1;
                  if (bc1 >= 10'd2) begin
                     phase_in = PH_WR_RESP;
                  end
                  snd = 1'b1;
               end
               PH_WR_RESP: begin
                  if (rx_byte[4:0] != sdh_pkg::DRESP_MASKED_OK) begin
                     do_fin = 1'b1;
                     fin_st = 1'b1;
                  end else begin
                     phase_in = PH_WR_BUSY1;
                     poll_in = '0;
                     snd = 1'b1;
                  end
               end
               PH_WR_BUSY1, PH_WR_BUSY2: begin
                  if (rx_byte != 8'd0) begin
                     if (phase_ff == PH_WR_BUSY2) begin
                        do_fin = 1'b1;
                     end else begin
                        phase_in = PH_WR_GAP;
                        snd = 1'b1;
                     end
                  end else if (poll_ff > {1'b0, cfg.data_poll}) begin
                     do_fin = 1'b1;
                     fin_st = 1'b1;
                  end else begin
                     poll_in = poll_ff + 17'd1;
                     snd = 1'b1;
                  end
               end
               PH_WR_GAP: begin
                  phase_in = PH_WR_BUSY2;
                  snd = 1'b1;
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end else if (phase_ff == PH_IDLE) begin
            case (func)
               sdh_pkg::FUNC_INIT: begin
                  v2_in = 1'b1;
                  retry_in = '0;
                  bc_in = '0;
                  phase_in = PH_INIT_CLK;
                  snd = 1'b1;
               end
               sdh_pkg::FUNC_READ: begin
                  do_start = 1'b1;
                  st_idx = sdh_pkg::CMD_RD_BLOCK;
                  st_arg = sector_address;
               end
               sdh_pkg::FUNC_LOAD: begin
                  buf_wr_en = 1'b1;
               end
               sdh_pkg::FUNC_WRITE: begin
                  do_start = 1'b1;
                  st_idx = sdh_pkg::CMD_WR_BLOCK;
                  st_arg = sector_address;
               end
               default: begin
                  buf_wr_en = 1'b0;
               end
            endcase
         end

         // command launch: standard cards take a byte address
         if (do_start) begin
            cidx_in = st_idx;
            carg_in = (!ba_ff && (st_idx == sdh_pkg::CMD_RD_BLOCK ||
                                  st_idx == sdh_pkg::CMD_WR_BLOCK)) ? {st_arg[22:0], 9'd0}
                                                                   : st_arg;
            phase_in = PH_CMD_TX;
            bc_in = '0;
            snd = 1'b1;
            snd_byte = {2'b01, st_idx};
         end
         if (do_fin) begin
            phase_in = PH_IDLE;
         end
      end
   end

   assign res_valid = snd | do_fin;

   always_comb begin
      res.tx_valid      = snd;
      res.tx_byte       = snd ? snd_byte : sdh_pkg::IDLE_BYTE;
      res.chip_select_n = do_fin | phase_in == PH_INIT_CLK | phase_in == PH_INIT_GAP |
                          phase_in == PH_WR_GAP;
      res.read_valid    = rv;
      res.read_byte     = rb;
      res.read_last     = rl;
      res.done_res      = do_fin;
      res.status        = fin_st;
      res.high_capacity = ba_in;
   end

   // next byte to send from the buffer, looked up for the state being entered
   assign buf_rd_addr = (phase_in == PH_WR_TOKEN) ? '0 :
                        (bc_in[sdh_pkg::BUF_AW-1:0] + 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         ba_ff    <= 1'b0;
         v2_ff    <= 1'b1;
         retry_ff <= '0;
         poll_ff  <= '0;
         bc_ff    <= '0;
         cidx_ff  <= '0;
         carg_ff  <= '0;
         lresp_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         ba_ff    <= ba_in;
         v2_ff    <= v2_in;
         retry_ff <= retry_in;
         poll_ff  <= poll_in;
         bc_ff    <= bc_in;
         cidx_ff  <= cidx_in;
         carg_ff  <= carg_in;
         lresp_ff <= lresp_in;
      end
   end

endmodule

>>> rtl/sd_card_spi_host_sequencer_top.sv
// SD card SPI-mode host sequencer: at most one SPI byte exchange per request or exchange item.
// A transfer is held in the input register while the core works on it combinationally, and its
// result is registered in the output register, which drives rsp_tvalid.
// Throughput: one item per cycle while rsp_tready is high; the output register stalls
// the input register only when a result is held. Buffer bytes come from a 512-entry RAM.
// Reset (synchronous, active high) returns the sequencer to idle and the limits to defaults.
module sd_card_spi_host_sequencer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // sector_address, buffer_index, data_byte, rx_byte, zeros
   input  logic [2:0]  req_tuser,  // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // tx_valid, tx_byte, chip_select_n, read_valid,
                                   // read_byte, done_res, status, high_capacity, zeros
   output logic        rsp_tlast,  // read_last
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   sdh_pkg::sdh_cfg_type cfg_ff;
   logic                 in_v_ff;
   logic [2:0]           func_ff;
   logic [63:0]          data_ff;
   logic                 out_v_ff;
   sdh_pkg::sdh_rsp_type out_ff;
   logic                 adv;
   logic                 res_valid;
   sdh_pkg::sdh_rsp_type res;
   logic [7:0]           buf_data;
   logic [sdh_pkg::BUF_AW-1:0] buf_rd_addr;
   logic                 buf_wr_en;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.idle_retry <= 8'd32;
         cfg_ff.cond_retry <= 8'd254;
         cfg_ff.opc_retry  <= 16'd4094;
         cfg_ff.resp_poll  <= 8'd254;
         cfg_ff.data_poll  <= 16'd65534;
      end else if (csr_we) begin
         case (csr_index)
            sdh_pkg::CSR_IDLE_RETRY: cfg_ff.idle_retry <= csr_wdata[7:0];
            sdh_pkg::CSR_COND_RETRY: cfg_ff.cond_retry <= csr_wdata[7:0];
            sdh_pkg::CSR_OPC_RETRY:  cfg_ff.opc_retry  <= csr_wdata;
            sdh_pkg::CSR_RESP_POLL:  cfg_ff.resp_poll  <= csr_wdata[7:0];
            sdh_pkg::CSR_DATA_POLL:  cfg_ff.data_poll  <= csr_wdata;
            default: cfg_ff <= cfg_ff;
         endcase
      end
   end

   // input register, advances when the output register can take a result
   assign adv        = in_v_ff && (!out_v_ff || rsp_tready);
   assign req_tready = !in_v_ff || adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (req_tready) begin
         in_v_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         func_ff <= req_tuser;
         data_ff <= req_tdata;
      end
   end

   sdh_wbuf u_wbuf (
      .clock   (clock),
      .wr_en   (buf_wr_en),
      .wr_addr (data_ff[40:32]),
      .wr_data (data_ff[48:41]),
      .rd_addr (buf_rd_addr),
      .rd_data (buf_data)
   );

   sdh_core u_core (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .item_valid     (adv),
      .func           (func_ff),
      .sector_address (data_ff[31:0]),
      .rx_byte        (data_ff[56:49]),
      .buf_data       (buf_data),
      .buf_rd_addr    (buf_rd_addr),
      .buf_wr_en      (buf_wr_en),
      .res_valid      (res_valid),
      .res            (res)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= res_valid;
      end else if (rsp_tready) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && res_valid) begin
         out_ff <= res;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tlast  = out_ff.read_last;
   assign rsp_tdata  = {2'b00, out_ff.high_capacity, out_ff.status, out_ff.done_res,
                        out_ff.read_byte, out_ff.read_valid, out_ff.chip_select_n,
                        out_ff.tx_byte, out_ff.tx_valid};

   // a completion never asks for another exchange and releases the card
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_ff.done_res |-> !out_ff.tx_valid && out_ff.chip_select_n)
      else $error("completion with exchange or card selected");

   // sector data only arrives alongside a further exchange
   a_read_tx: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_ff.read_valid |-> out_ff.tx_valid && !out_ff.done_res)
      else $error("read byte without exchange");

   // last marker only on a data byte
   a_last_data: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_ff.read_last |-> out_ff.read_valid)
      else $error("read_last without read byte");

endmodule
